// ===== src/mie_pkg.sv =====
// Package for the extended Euclidean modular inverse core.
// Holds field widths, the datapath operation code and the status struct.
// Used by mie_dp, mie_ctrl and modular_inverse_ext_euclid_core.
package mie_pkg;

  localparam int unsigned FW = 31;          // field width of value, modulus, inverse
  localparam int unsigned DW = FW + 1;      // working width: one guard bit for shifting
  localparam int unsigned CW = $clog2(DW);  // shift counter width

  typedef logic [FW-1:0] field_t;
  typedef logic [DW-1:0] word_t;
  typedef logic [CW-1:0] cnt_t;

  // Operation issued by the sequencer to the datapath each cycle
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LOAD,
    OP_ALIGN,
    OP_SUB,
    OP_SWAP,
    OP_FOLD,
    OP_FINAL
  } op_t;

  // Status returned by the datapath
  typedef struct packed {
    logic fits;      // second operand of the shared subtractor <= first
    logic cnt_zero;  // no shift left to undo
    logic rb_zero;   // divisor is zero: Euclid finished
  } stat_t;

endpackage

// ===== src/mie_dp.sv =====
// Datapath of the modular inverse core: remainder and coefficient registers
// around one shared subtract/compare unit. Depends on mie_pkg.
module mie_dp (
  input  logic               clk,
  input  mie_pkg::op_t       op,
  input  mie_pkg::field_t    in_value,
  input  mie_pkg::field_t    in_modulus,
  output mie_pkg::stat_t     stat,
  output mie_pkg::field_t    res_inverse,
  output logic               res_no_inverse
);

  mie_pkg::field_t ra_r;    // dividend, reduced in place to the remainder
  mie_pkg::field_t rb_r;    // divisor
  mie_pkg::field_t m_r;     // modulus
  mie_pkg::word_t  sd_r;    // shifted divisor
  mie_pkg::word_t  sm_r;    // shifted coefficient of the divisor
  mie_pkg::word_t  ca_r;    // coefficient magnitude paired with ra, accumulates
  mie_pkg::word_t  cb_r;    // coefficient magnitude paired with rb
  mie_pkg::cnt_t   cnt_r;   // pending shifts
  logic            even_r;  // ca carries a positive sign

  mie_pkg::word_t    opa;
  mie_pkg::word_t    opb;
  logic [mie_pkg::DW:0] diff;
  logic              ge;
  mie_pkg::field_t   inv_sel;
  logic              has_inv;

  // Shared subtractor: compare and difference in one
  always_comb begin
    opa = {1'b0, ra_r};
    opb = sd_r;
    case (op)
      mie_pkg::OP_FOLD: begin
        opa = ca_r;
        opb = {1'b0, m_r};
      end
      mie_pkg::OP_FINAL: begin
        opa = {1'b0, m_r};
        opb = ca_r;
      end
      default: begin
        opa = {1'b0, ra_r};
        opb = sd_r;
      end
    endcase
  end

  assign diff = {1'b0, opa} - {1'b0, opb};
  assign ge   = ~diff[mie_pkg::DW];

  assign stat.fits     = ge;
  assign stat.cnt_zero = (cnt_r == '0);
  assign stat.rb_zero  = (rb_r == '0);

  // Negative coefficient is folded as m - |c|
  assign inv_sel = (even_r || ca_r == '0) ? ca_r[mie_pkg::FW-1:0] : diff[mie_pkg::FW-1:0];
  assign has_inv = (ra_r == mie_pkg::field_t'(1)) && (m_r != '0);

  assign res_inverse    = has_inv ? inv_sel : '0;
  assign res_no_inverse = ~has_inv;

  always_ff @(posedge clk) begin
    case (op)
      mie_pkg::OP_LOAD: begin
        ra_r   <= in_value;
        rb_r   <= in_modulus;
        m_r    <= in_modulus;
        sd_r   <= {1'b0, in_modulus};
        sm_r   <= '0;
        ca_r   <= mie_pkg::word_t'(1);
        cb_r   <= '0;
        cnt_r  <= '0;
        even_r <= 1'b1;
      end
      mie_pkg::OP_ALIGN: begin
        if (ge) begin
          sd_r  <= {sd_r[mie_pkg::DW-2:0], 1'b0};
          sm_r  <= {sm_r[mie_pkg::DW-2:0], 1'b0};
          cnt_r <= cnt_r + mie_pkg::cnt_t'(1);
        end
      end
      mie_pkg::OP_SUB: begin
        if (ge) begin
          ra_r <= diff[mie_pkg::FW-1:0];
          ca_r <= ca_r + sm_r;
        end
        if (cnt_r != '0) begin
          sd_r  <= {1'b0, sd_r[mie_pkg::DW-1:1]};
          sm_r  <= {1'b0, sm_r[mie_pkg::DW-1:1]};
          cnt_r <= cnt_r - mie_pkg::cnt_t'(1);
        end
      end
      mie_pkg::OP_SWAP: begin
        ra_r   <= rb_r;
        rb_r   <= ra_r;
        ca_r   <= cb_r;
        cb_r   <= ca_r;
        sd_r   <= {1'b0, ra_r};
        sm_r   <= ca_r;
        cnt_r  <= '0;
        even_r <= ~even_r;
      end
      mie_pkg::OP_FOLD: begin
        if (ge) begin
          ca_r <= diff[mie_pkg::DW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/mie_ctrl.sv =====
// Sequencer of the modular inverse core: steps the datapath through the
// align, subtract and swap phases of each Euclid step. Depends on mie_pkg.
module mie_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            out_free,
  input  mie_pkg::stat_t  stat,
  output mie_pkg::op_t    op,
  output logic            load_out
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALIGN,
    S_SUB,
    S_SWAP,
    S_FOLD,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);
  assign load_out = (state_r == S_DONE) && out_free;

  always_comb begin
    state_nxt = state_r;
    op        = mie_pkg::OP_IDLE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = mie_pkg::OP_LOAD;
          state_nxt = S_ALIGN;
        end
      end
      S_ALIGN: begin
        if (stat.rb_zero) begin
          state_nxt = S_FOLD;
        end else begin
          op = mie_pkg::OP_ALIGN;
          if (!stat.fits) state_nxt = S_SUB;
        end
      end
      S_SUB: begin
        op = mie_pkg::OP_SUB;
        if (stat.cnt_zero) state_nxt = S_SWAP;
      end
      S_SWAP: begin
        op        = mie_pkg::OP_SWAP;
        state_nxt = S_ALIGN;
      end
      S_FOLD: begin
        op        = mie_pkg::OP_FOLD;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        op = mie_pkg::OP_FINAL;
        if (out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/modular_inverse_ext_euclid_core.sv =====
// Top level of the extended Euclidean modular inverse core.
// Instantiates mie_ctrl and mie_dp; depends on mie_pkg.
//
// Usage: in_value / in_modulus arrive on a valid/ready channel and each item
//   gives one item on out_inverse / out_no_inverse: the inverse in
//   0..modulus-1, or 0 with out_no_inverse set when gcd(value, modulus) is
//   not 1 or the modulus is zero.
// Timing: one item at a time on a single shared subtract/compare unit. In
//   each Euclid step the divisor is shifted up one bit a cycle until it
//   passes the dividend, then walked back with a conditional subtract, and
//   the remainder pair is swapped. Each item is loaded, runs its steps
//   until the zero divisor is seen, has its coefficient folded and gives
//   its result. in_ready is high only while the core is idle.
// Output: the result sits in an output register and the core takes the next
//   item while it waits; if the receiver stalls, a finished result is held
//   in the datapath while the sequencer waits, until the register frees.
// Reset: rst_n (synchronous, active low) empties the output register and
//   returns the sequencer to idle; any item in flight is dropped.
module modular_inverse_ext_euclid_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  mie_pkg::field_t  in_value,
  input  mie_pkg::field_t  in_modulus,
  output logic             out_valid,
  input  logic             out_ready,
  output mie_pkg::field_t  out_inverse,
  output logic             out_no_inverse
);

  mie_pkg::op_t    op;
  mie_pkg::stat_t  stat;
  mie_pkg::field_t res_inverse;
  logic            res_no_inverse;
  logic            load_out;
  logic            out_free;

  logic            out_valid_r;
  mie_pkg::field_t out_inverse_r;
  logic            out_no_inverse_r;

  // Output register is free when empty or being drained this cycle
  assign out_free = ~out_valid_r | out_ready;

  mie_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .stat     (stat),
    .op       (op),
    .load_out (load_out)
  );

  mie_dp u_dp (
    .clk            (clk),
    .op             (op),
    .in_value       (in_value),
    .in_modulus     (in_modulus),
    .stat           (stat),
    .res_inverse    (res_inverse),
    .res_no_inverse (res_no_inverse)
  );

  // Valid flag: reset-cleared control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_inverse_r    <= res_inverse;
      out_no_inverse_r <= res_no_inverse;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inverse    = out_inverse_r;
  assign out_no_inverse = out_no_inverse_r;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for modular_inverse_ext_euclid_core.
// Predicts each inverse with its own extended Euclid and checks every result item in order.
// Depends on mie_pkg and the core RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef mie_pkg::field_t field_t;

  // Watchdog: cycles in a row with no item moving on either channel.
  // The limit lies far above the slowest item, the longest input gaps and
  // the short output stalls.
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned TAIL_CYCLES  = 300;
  localparam int unsigned RANDOM_ITEMS = 1530;
  localparam int unsigned STEADY_FIRST = 600;   // no idling on either side
  localparam int unsigned STEADY_LAST  = 800;   // for this span of random items
  localparam field_t      FIELD_MAX    = '1;

  typedef struct packed {
    field_t inverse;
    logic   no_inverse;
  } inv_result_t;

  // Holds the inverses still owed by the core, oldest first.
  class inverse_scoreboard;
    inv_result_t pending_inverses[$];
    int unsigned mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    // Iterative extended Euclid. Only the magnitude of the coefficient of
    // value is tracked; its sign flips every remainder step, so the parity
    // of the step count says whether to negate it at the end.
    static function inv_result_t euclid_inverse(field_t value, field_t modulus);
      bit [63:0] rem_prev, rem_cur, mag_prev, mag_cur, quot, tmp;
      bit positive;
      inv_result_t res;
      res.inverse    = '0;
      res.no_inverse = 1'b1;
      if (modulus == '0)
        return res;
      rem_prev = 64'(value);
      rem_cur  = 64'(modulus);
      mag_prev = 64'd1;
      mag_cur  = 64'd0;
      positive = 1'b1;
      while (rem_cur != 64'd0) begin
        quot     = rem_prev / rem_cur;
        tmp      = rem_prev - quot * rem_cur;
        rem_prev = rem_cur;
        rem_cur  = tmp;
        tmp      = mag_prev + quot * mag_cur;
        mag_prev = mag_cur;
        mag_cur  = tmp;
        positive = !positive;
      end
      if (rem_prev != 64'd1)
        return res;
      mag_prev = mag_prev % 64'(modulus);
      if (!positive && mag_prev != 64'd0)
        mag_prev = 64'(modulus) - mag_prev;
      res.inverse    = field_t'(mag_prev);
      res.no_inverse = 1'b0;
      return res;
    endfunction

    function void flag_error(string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("[%0t] ERROR: %s", $realtime, msg);
    endfunction

    function void note_operands(field_t value, field_t modulus);
      pending_inverses.push_back(euclid_inverse(value, modulus));
    endfunction

    function void check_inverse(field_t inverse, logic no_inverse);
      inv_result_t want;
      if (pending_inverses.size() == 0) begin
        flag_error($sformatf("result item with none pending: inverse=%0d no_inverse=%b",
                             inverse, no_inverse));
        return;
      end
      want = pending_inverses.pop_front();
      if (want.inverse !== inverse || want.no_inverse !== no_inverse)
        flag_error($sformatf("expected inverse=%0d no_inverse=%b, got inverse=%0d no_inverse=%b",
                             want.inverse, want.no_inverse, inverse, no_inverse));
    endfunction
  endclass

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_ready;
  field_t in_value;
  field_t in_modulus;
  logic   out_valid;
  logic   out_ready;
  field_t out_inverse;
  logic   out_no_inverse;

  logic        steady;        // set during the stretch with no idling
  int unsigned quiet_cycles;
  inverse_scoreboard sb;

  modular_inverse_ext_euclid_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .in_modulus     (in_modulus),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_inverse    (out_inverse),
    .out_no_inverse (out_no_inverse)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Receiver: stalls about 30% of cycles, never during the steady stretch.
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 30);
  end

  // Monitor and watchdog. All reads here see values from before the edge,
  // so the order against the drivers does not matter. The output is checked
  // before the input is noted: a result never belongs to an item accepted
  // at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_inverse(out_inverse, out_no_inverse);
      if (in_valid && in_ready)
        sb.note_operands(in_value, in_modulus);
      if ((out_valid && out_ready) || (in_valid && in_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one item. Valid is lowered only when a gap is taken, so it is
  // never dropped and raised again within one edge. Gaps are mostly short
  // runs of idle cycles; now and then a long one lets the core sit idle.
  task automatic send_operands(field_t value, field_t modulus);
    int unsigned gap;
    gap = 0;
    if (!steady) begin
      if ($urandom_range(0, 19) == 0)
        gap = $urandom_range(20, 160);
      while ($urandom_range(0, 99) < 30)
        gap++;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_value   <= value;
    in_modulus <= modulus;
    do @(posedge clk); while (!in_ready);
  endtask

  // Random operands, weighted towards the corners of the algorithm:
  // tiny and zero moduli, zero values, values above the modulus and
  // consecutive Fibonacci numbers (the longest Euclid runs).
  task automatic send_random_operands();
    int unsigned sel, steps, fib_lo, fib_hi, fib_nx;
    field_t value, modulus;
    sel     = $urandom_range(0, 99);
    value   = field_t'($urandom);
    modulus = field_t'($urandom);
    if (sel < 5) begin
      modulus = field_t'($urandom_range(0, 1));
    end else if (sel < 20) begin
      modulus = field_t'($urandom_range(2, 64));
      value   = field_t'($urandom_range(0, 200));
    end else if (sel < 28) begin
      steps  = $urandom_range(1, 44);
      fib_lo = 1;
      fib_hi = 1;
      repeat (steps) begin
        fib_nx = fib_lo + fib_hi;
        fib_lo = fib_hi;
        fib_hi = fib_nx;
      end
      value   = field_t'($urandom_range(0, 1) ? fib_lo : fib_hi);
      modulus = field_t'((value == field_t'(fib_lo)) ? fib_hi : fib_lo);
    end else if (sel < 33) begin
      value = '0;
    end else if (sel < 45) begin
      // narrower operands: short runs, quotients of many sizes
      modulus = modulus >> $urandom_range(1, 29);
      value   = value >> $urandom_range(0, 30);
    end
    send_operands(value, modulus);
  endtask

  initial begin
    sb           = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_value     = '0;
    in_modulus   = '0;
    out_ready    = 1'b0;
    steady       = 1'b0;
    quiet_cycles = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero modulus, modulus of one, zero value, value at or
    // above the modulus, no inverse, largest fields and the worst-case
    // Fibonacci pair.
    send_operands('0, '0);
    send_operands(field_t'(1), '0);
    send_operands(FIELD_MAX, '0);
    send_operands('0, field_t'(1));
    send_operands(FIELD_MAX, field_t'(1));
    send_operands('0, field_t'(7));
    send_operands('0, FIELD_MAX);
    send_operands(field_t'(1), FIELD_MAX);
    send_operands(FIELD_MAX - field_t'(1), FIELD_MAX);
    send_operands(FIELD_MAX, FIELD_MAX);
    send_operands(FIELD_MAX, FIELD_MAX - field_t'(1));
    send_operands(field_t'(3), field_t'(7));
    send_operands(field_t'(10), field_t'(7));
    send_operands(field_t'(7), field_t'(7));
    send_operands(field_t'(6), field_t'(9));
    send_operands(field_t'(1), field_t'(2));
    send_operands(field_t'(1134903170), field_t'(1836311903));
    send_operands(field_t'(1836311903), field_t'(1134903170));
    send_operands(31'h2AAA_AAAA, 31'h5555_5555);
    send_operands(field_t'(2), 31'h4000_0000);
    send_operands(field_t'(3), 31'h4000_0000);
    send_operands(field_t'(12345), 31'h7FFF_FFF0);

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      steady <= (n >= STEADY_FIRST) && (n < STEADY_LAST);
      send_random_operands();
    end
    in_valid <= 1'b0;
    steady   <= 1'b0;

    // One edge first so the last item is noted, then drain and let the
    // core sit a while to catch any stray result item.
    @(posedge clk);
    while (sb.pending_inverses.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.pending_inverses.size() != 0)
      sb.flag_error($sformatf("%0d result items never arrived", sb.pending_inverses.size()));
    if (sb.mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== modular_inverse_ext_euclid_core.f =====
src/mie_pkg.sv
src/mie_dp.sv
src/mie_ctrl.sv
src/modular_inverse_ext_euclid_core.sv
tb/tb_top.sv
